// File: src/svp_pkg.sv
// Shared types, constants and helper functions for the version string parser.
package svp_pkg;

  // Longest string accepted before the status reports too long
  localparam int MAX_LENGTH = 256;
  // Counter width: holds the saturation cap MAX_LENGTH + 1
  localparam int CNT_W = $clog2(MAX_LENGTH + 2);
  // Width of the layout fields on the result channel
  localparam int OUT_W = 9;

  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_LENGTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_MAJOR,
    PH_MINOR,
    PH_PATCH,
    PH_PRE,
    PH_BUILD
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_TOO_LONG
  } status_t;

  // Parser state carried from one item to the next
  typedef struct packed {
    phase_t                  phase;
    logic [CNT_W-1:0]        char_count;
    logic [4:0][CNT_W-1:0]   lens;
    logic [CNT_W-1:0]        start;
    logic [CNT_W-1:0]        pending;
    logic                    lzero;
    logic                    err;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_LEAD,
    char_count: '0,
    lens:       '0,
    start:      '0,
    pending:    '0,
    lzero:      1'b0,
    err:        1'b0
  };

  // One result item
  typedef struct packed {
    status_t           status;
    logic [OUT_W-1:0]  major_offset;
    logic [OUT_W-1:0]  major_length;
    logic [OUT_W-1:0]  minor_length;
    logic [OUT_W-1:0]  patch_length;
    logic [OUT_W-1:0]  prerelease_length;
    logic [OUT_W-1:0]  build_length;
  } result_t;

  // Add two counts, saturating at the cap
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, CNT_CAP}) ? CNT_CAP : s[CNT_W-1:0];
  endfunction

endpackage

// File: src/svp_if.sv
// Valid/ready channel interfaces for characters in and results out.
interface svp_char_if;
  import svp_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface svp_result_if;
  import svp_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic [OUT_W-1:0] major_offset;
  logic [OUT_W-1:0] major_length;
  logic [OUT_W-1:0] minor_length;
  logic [OUT_W-1:0] patch_length;
  logic [OUT_W-1:0] prerelease_length;
  logic [OUT_W-1:0] build_length;

  modport source (output valid, output status, output major_offset, output major_length,
                  output minor_length, output patch_length, output prerelease_length,
                  output build_length, input ready);
  modport sink   (input valid, input status, input major_offset, input major_length,
                  input minor_length, input patch_length, input prerelease_length,
                  input build_length, output ready);
endinterface

// File: src/svp_step.sv
// Per-character next-state and result logic of the version string parser.
module svp_step (
  input  svp_pkg::state_t  cur,
  input  logic [7:0]       char_code,
  input  logic             final_char,
  output svp_pkg::state_t  nxt,
  output svp_pkg::result_t res
);
  import svp_pkg::*;

  state_t           upd;
  phase_t           ph;
  logic             ws;
  logic             digit;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] tmp;
  logic             ok;
  logic             too_long;

  always_comb begin
    upd   = cur;
    ph    = cur.phase;
    len   = '0;
    tmp   = '0;
    ws    = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

    // Character handling, frozen once an error is seen
    if (!cur.err) begin
      if (ws) begin
        if (cur.phase != PH_LEAD) begin
          upd.pending = sat_add(cur.pending, CNT_ONE);
        end
      end else begin
        if (ph == PH_LEAD) begin
          upd.start = cur.char_count;
          ph = PH_MAJOR;
        end
        upd.phase = ph;
        case (ph)
          PH_MAJOR, PH_MINOR, PH_PATCH: begin
            len = (ph == PH_MAJOR) ? cur.lens[0] :
                  (ph == PH_MINOR) ? cur.lens[1] : cur.lens[2];
            if (cur.pending != '0) begin
              // inner whitespace inside a number
              upd.err = 1'b1;
            end else if (digit) begin
              if (len == CNT_ONE && cur.lzero) begin
                upd.err = 1'b1;
              end
              if (len == '0 && char_code == CH_ZERO) begin
                upd.lzero = 1'b1;
              end
              tmp = sat_add(len, CNT_ONE);
              if (ph == PH_MAJOR) begin
                upd.lens[0] = tmp;
              end else if (ph == PH_MINOR) begin
                upd.lens[1] = tmp;
              end else begin
                upd.lens[2] = tmp;
              end
            end else if (char_code == CH_DOT && ph != PH_PATCH) begin
              if (len == '0) begin
                upd.err = 1'b1;
              end
              upd.phase = (ph == PH_MAJOR) ? PH_MINOR : PH_PATCH;
              upd.lzero = 1'b0;
            end else if (ph == PH_PATCH &&
                         (char_code == CH_MINUS || char_code == CH_PLUS)) begin
              if (len == '0) begin
                upd.err = 1'b1;
              end
              upd.phase = (char_code == CH_MINUS) ? PH_PRE : PH_BUILD;
              upd.lzero = 1'b0;
            end else begin
              upd.err = 1'b1;
            end
          end
          PH_PRE: begin
            tmp = sat_add(cur.lens[3], cur.pending);
            if (char_code == CH_PLUS) begin
              if (tmp == '0) begin
                upd.err = 1'b1;
              end
              upd.lens[3] = tmp;
              upd.phase   = PH_BUILD;
            end else begin
              upd.lens[3] = sat_add(tmp, CNT_ONE);
            end
          end
          PH_BUILD: begin
            upd.lens[4] = sat_add(cur.lens[4], sat_add(cur.pending, CNT_ONE));
          end
          default: begin
          end
        endcase
        upd.pending = '0;
      end
    end
    upd.char_count = sat_add(cur.char_count, CNT_ONE);

    // Final checks on the updated state
    case (upd.phase)
      PH_PATCH: ok = !upd.err && upd.lens[2] != '0;
      PH_PRE:   ok = !upd.err && upd.lens[3] != '0;
      PH_BUILD: ok = !upd.err && upd.lens[4] != '0;
      default:  ok = 1'b0;
    endcase
    too_long = upd.char_count > CNT_MAX;

    res = '0;
    if (too_long) begin
      res.status = ST_TOO_LONG;
    end else if (!ok) begin
      res.status = ST_INVALID;
    end else begin
      res.status            = ST_OK;
      res.major_offset      = OUT_W'(upd.start);
      res.major_length      = OUT_W'(upd.lens[0]);
      res.minor_length      = OUT_W'(upd.lens[1]);
      res.patch_length      = OUT_W'(upd.lens[2]);
      res.prerelease_length = OUT_W'(upd.lens[3]);
      res.build_length      = OUT_W'(upd.lens[4]);
    end

    nxt = final_char ? STATE_RESET : upd;
  end

endmodule

// File: src/semver_string_parser_unit.sv
// Top level of the version string parser: state and result registers.
//
// Usage: the string arrives on the chars channel one byte per item, with
// final_char set on its last byte. For each string one item leaves on the
// result channel: status (ok, invalid, too long) and, when ok, the offset of
// the major number and the lengths of major, minor, patch, pre-release and
// build. No item leaves for bytes that are not final.
// Latency: the result item is valid in the cycle after the final byte is accepted.
// Throughput: one byte per cycle while chars.ready is high, with the parser state
// updated on each accepted byte; the next string may start right after a final byte.
// Stall: the result sits in an output register; chars.ready stays high while
// that register is empty or being emptied, so bytes keep flowing while a
// result waits only if the receiver takes it. With a result held and
// result.ready low, chars.ready is low.
// Reset: synchronous rst returns the parser to the leading-whitespace phase
// with all counts cleared and empties the output register.
module semver_string_parser_unit (
  input logic               clk,
  input logic               rst,
  svp_char_if.sink          chars,
  svp_result_if.source      result
);
  import svp_pkg::*;

  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res;
  logic    res_valid;
  logic    accept;

  assign chars.ready = !res_valid || result.ready;
  assign accept      = chars.valid && chars.ready;

  svp_step u_step (
    .cur        (st),
    .char_code  (chars.char_code),
    .final_char (chars.final_char),
    .nxt        (st_next),
    .res        (res_next)
  );

  // Parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && chars.final_char) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.final_char) begin
      res <= res_next;
    end
  end

  assign result.valid             = res_valid;
  assign result.status            = res.status;
  assign result.major_offset      = res.major_offset;
  assign result.major_length      = res.major_length;
  assign result.minor_length      = res.minor_length;
  assign result.patch_length      = res.patch_length;
  assign result.prerelease_length = res.prerelease_length;
  assign result.build_length      = res.build_length;

  // A final byte always produces a result in the next cycle
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && chars.final_char |=> res_valid)
    else $error("final byte did not produce a result");

  // After a final byte the parser is back at its start state
  a_final_resets_state: assert property (@(posedge clk) disable iff (rst)
    accept && chars.final_char |=> st.phase == PH_LEAD && st.char_count == '0)
    else $error("parser state not cleared after final byte");

  // A non-final byte never leaves a fresh result behind
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    accept && !chars.final_char |=> !res_valid)
    else $error("result appeared without a final byte");

  // A failed status carries an all-zero layout
  a_fail_zero_layout: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.major_offset == '0 &&
      res.major_length == '0 && res.minor_length == '0 && res.patch_length == '0 &&
      res.prerelease_length == '0 && res.build_length == '0)
    else $error("layout not cleared on failed status");

  // Once past the leading blanks, at least one byte has been counted
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    st.phase != PH_LEAD |-> st.char_count != '0)
    else $error("parser left leading phase without counting a byte");

endmodule
